@@ rtl/core/ilp_pkg.sv @@
// Package for the integer literal parser: character codes, radix and type codes.
// Holds the digit decode function that the parser core uses.
// No dependencies.
package ilp_pkg;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_U     = 8'h75;
	localparam logic [7:0] CHAR_L     = 8'h6C;
	localparam logic [7:0] CHAR_S     = 8'h73;
	localparam logic [7:0] CHAR_I     = 8'h69;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;

	localparam logic [4:0] DIGIT_NONE = 5'd16;
	localparam logic [4:0] BASE_OCT   = 5'd8;
	localparam logic [4:0] BASE_DEC   = 5'd10;
	localparam logic [4:0] BASE_HEX   = 5'd16;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	typedef enum logic [2:0] {
		TYPE_I32 = 3'd0,
		TYPE_I64 = 3'd1,
		TYPE_I16 = 3'd2,
		TYPE_U32 = 3'd3,
		TYPE_U64 = 3'd4,
		TYPE_U16 = 3'd5
	} lit_type_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FLOAT   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = 5'(c - CHAR_ZERO);
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			d = 5'(c - CHAR_LA) + 5'd10;
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = 5'(c - CHAR_UA) + 5'd10;
		end
		return d;
	endfunction

	function automatic logic is_width_letter(input logic [7:0] c);
		return (c == CHAR_L) || (c == CHAR_S) || (c == CHAR_I);
	endfunction

endpackage

@@ rtl/core/ilp_char_if.sv @@
// Character request channel of the integer literal parser.
// Carries valid, ready, one character and the last flag. No dependencies.
interface ilp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source (output valid, output char_in, output is_last, input ready);
	modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

@@ rtl/core/ilp_result_if.sv @@
// Result request channel of the integer literal parser.
// Carries valid, ready, the value word, type code and status. No dependencies.
interface ilp_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_word;
	logic [2:0]  type_code;
	logic [1:0]  status;

	modport source (output valid, output value_word, output type_code, output status,
		input ready);
	modport sink   (input valid, input value_word, input type_code, input status,
		output ready);
endinterface

@@ rtl/core/integer_literal_parser.sv @@
// Integer literal parser: input register, one pass of decode and accumulate, result register.
// Depends on ilp_pkg, ilp_char_if and ilp_result_if.
//
// channel  | dir | payload                              | notes
// in_ch    | in  | char_in[7:0], is_last                | one request per character
// out_ch   | out | value_word[63:0], type_code, status  | one request per literal
//
// One character per cycle sustained, unless a last character waits on a stalled result.
// The last character passes the input register, then the shift-add, then the result register.
// Reset clears the parse state and both valid flags.
// A stalled result holds only a last character in the input register; other characters flow.
module integer_literal_parser (
	input  logic              clk,
	input  logic              arst_n,
	ilp_char_if.sink          in_ch,
	ilp_result_if.source      out_ch
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;

	logic [1:0]        char_index_q;
	logic              negative_q;
	ilp_pkg::radix_t   radix_q;
	logic [63:0]       accum_now_q;
	logic [63:0]       accum_last_q;
	logic [7:0]        prev_char_q;
	logic [1:0]        error_q;

	logic              out_valid_q;
	logic [63:0]       out_word_q;
	logic [2:0]        out_type_q;
	logic [1:0]        out_status_q;

	logic              advance;
	logic              had_prev;
	logic [1:0]        dpos;
	logic              invalid;
	logic              consumed;
	ilp_pkg::radix_t   radix_d;
	logic              negative_d;
	logic [1:0]        error_d;
	logic [63:0]       accum_d;
	logic [4:0]        digit;
	logic [4:0]        base;
	logic [63:0]       scaled;
	ilp_pkg::lit_type_t type_d;
	logic [1:0]        drop;
	logic [63:0]       word_sel;
	logic [63:0]       word_neg;
	logic [63:0]       mask;
	logic [63:0]       word_d;

	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.char_in;
			last_s1 <= in_ch.is_last;
		end
	end

	always_comb begin
		had_prev   = char_index_q != 2'd0;
		dpos       = char_index_q - {1'b0, negative_q};
		invalid    = had_prev && ilp_pkg::is_width_letter(prev_char_q) &&
			(!last_s1 || char_s1 != ilp_pkg::CHAR_U);
		consumed   = 1'b0;
		radix_d    = radix_q;
		negative_d = negative_q;
		error_d    = error_q;
		accum_d    = accum_now_q;
		digit      = ilp_pkg::digit_value(char_s1);
		base       = ilp_pkg::BASE_DEC;
		scaled     = '0;

		if (char_s1 == ilp_pkg::CHAR_DOT) begin
			error_d = ilp_pkg::STATUS_FLOAT;
		end else if (char_index_q == 2'd0 && char_s1 == ilp_pkg::CHAR_MINUS) begin
			negative_d = 1'b1;
		end else begin
			if (dpos == 2'd1 && prev_char_q == ilp_pkg::CHAR_ZERO) begin
				if (char_s1 == ilp_pkg::CHAR_X && !last_s1) begin
					radix_d  = ilp_pkg::RADIX_HEX;
					consumed = 1'b1;
				end else begin
					radix_d = ilp_pkg::RADIX_OCT;
				end
			end
			unique case (radix_d)
				ilp_pkg::RADIX_HEX: begin
					base   = ilp_pkg::BASE_HEX;
					scaled = {accum_now_q[59:0], 4'd0};
				end
				ilp_pkg::RADIX_OCT: begin
					base   = ilp_pkg::BASE_OCT;
					scaled = {accum_now_q[60:0], 3'd0};
				end
				default: begin
					base   = ilp_pkg::BASE_DEC;
					scaled = {accum_now_q[60:0], 3'd0} + {accum_now_q[62:0], 1'b0};
				end
			endcase
			if (!consumed) begin
				if (digit < base) begin
					accum_d = scaled + {60'd0, digit[3:0]};
				end else if (ilp_pkg::is_width_letter(char_s1) && !last_s1) begin
					invalid = invalid;
				end else if (last_s1 && (char_s1 == ilp_pkg::CHAR_U ||
					ilp_pkg::is_width_letter(char_s1))) begin
					invalid = invalid;
				end else begin
					invalid = 1'b1;
				end
			end
		end
		if (invalid && error_d == ilp_pkg::STATUS_OK) begin
			error_d = ilp_pkg::STATUS_INVALID;
		end
	end

	always_comb begin
		type_d = ilp_pkg::TYPE_I32;
		drop   = 2'd0;
		priority if (char_s1 == ilp_pkg::CHAR_U) begin
			drop   = 2'd1;
			type_d = ilp_pkg::TYPE_U32;
			if (had_prev && ilp_pkg::is_width_letter(prev_char_q)) begin
				drop = 2'd2;
				if (prev_char_q == ilp_pkg::CHAR_L) begin
					type_d = ilp_pkg::TYPE_U64;
				end else if (prev_char_q == ilp_pkg::CHAR_S) begin
					type_d = ilp_pkg::TYPE_U16;
				end
			end
		end else if (char_s1 == ilp_pkg::CHAR_L) begin
			drop   = 2'd1;
			type_d = ilp_pkg::TYPE_I64;
		end else if (char_s1 == ilp_pkg::CHAR_S) begin
			drop   = 2'd1;
			type_d = ilp_pkg::TYPE_I16;
		end else if (char_s1 == ilp_pkg::CHAR_I) begin
			drop   = 2'd1;
		end else begin
			drop   = 2'd0;
		end

		unique case (drop)
			2'd2:    word_sel = accum_last_q;
			2'd1:    word_sel = accum_now_q;
			default: word_sel = accum_d;
		endcase

		unique case (type_d)
			ilp_pkg::TYPE_I64:                   mask = {64{1'b1}};
			ilp_pkg::TYPE_I16, ilp_pkg::TYPE_U16: mask = 64'h0000_0000_0000_FFFF;
			default:                             mask = 64'h0000_0000_FFFF_FFFF;
		endcase

		word_neg = 64'd0 - word_sel;
		word_d   = word_sel;
		if (negative_d && type_d != ilp_pkg::TYPE_U64) begin
			word_d = (word_sel & ~mask) | (word_neg & mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q <= 2'd0;
			negative_q   <= 1'b0;
			radix_q      <= ilp_pkg::RADIX_DEC;
			accum_now_q  <= '0;
			accum_last_q <= '0;
			prev_char_q  <= '0;
			error_q      <= ilp_pkg::STATUS_OK;
		end else if (advance) begin
			if (last_s1) begin
				char_index_q <= 2'd0;
				negative_q   <= 1'b0;
				radix_q      <= ilp_pkg::RADIX_DEC;
				accum_now_q  <= '0;
				accum_last_q <= '0;
				prev_char_q  <= '0;
				error_q      <= ilp_pkg::STATUS_OK;
			end else begin
				if (char_index_q != 2'd3) begin
					char_index_q <= char_index_q + 2'd1;
				end
				negative_q   <= negative_d;
				radix_q      <= radix_d;
				accum_now_q  <= accum_d;
				accum_last_q <= accum_now_q;
				prev_char_q  <= char_s1;
				error_q      <= error_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			if (error_d != ilp_pkg::STATUS_OK) begin
				out_word_q <= '0;
				out_type_q <= ilp_pkg::TYPE_I32;
			end else begin
				out_word_q <= word_d;
				out_type_q <= type_d;
			end
			out_status_q <= error_d;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.value_word = out_word_q;
	assign out_ch.type_code  = out_type_q;
	assign out_ch.status     = out_status_q;

endmodule

@@ rtl/core/ilp_checker.sv @@
// Port checker for the integer literal parser, bound to the top level.
// Depends on ilp_pkg and the top level's channel ports.
module ilp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] value_word,
	input logic [2:0]  type_code,
	input logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(value_word) && $stable(status))
		else $error("result payload changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ilp_pkg::STATUS_OK |-> value_word == 64'd0 &&
		type_code == ilp_pkg::TYPE_I32)
		else $error("error result carries a value");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3 && type_code <= ilp_pkg::TYPE_U16)
		else $error("result code out of range");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.value_word (out_ch.value_word),
	.type_code  (out_ch.type_code),
	.status     (out_ch.status)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for integer_literal_parser: streams literals one character per request
// and checks each result against a built-in parse predictor.
// Depends on ilp_pkg, ilp_char_if, ilp_result_if and the parser core.
module testbench;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [63:0]        value_word;
		ilp_pkg::lit_type_t type_code;
		ilp_pkg::status_t   status;
	} literal_result_t;

	logic clk;
	logic arst_n;

	ilp_char_if   char_ch();
	ilp_result_if result_ch();

	integer_literal_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (char_ch),
		.out_ch (result_ch)
	);

	literal_result_t expected_literals[$];
	logic [7:0]      literal_buf[$];
	int              mismatch_count = 0;
	int              cycle_count = 0;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;

	logic [1:0]       lit_index;
	logic             lit_negative;
	ilp_pkg::radix_t  lit_radix;
	logic [63:0]      acc_now;
	logic [63:0]      acc_before_last;
	logic [63:0]      acc_before_second;
	logic [7:0]       lit_prev_char;
	ilp_pkg::status_t lit_status;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		literal_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_literals.size() == 0) begin
				flag_mismatch("result with no literal pending");
			end else begin
				want = expected_literals.pop_front();
				if (result_ch.value_word !== want.value_word)
					flag_mismatch($sformatf("value_word %h, want %h",
						result_ch.value_word, want.value_word));
				if (result_ch.type_code !== want.type_code)
					flag_mismatch($sformatf("type_code %0d, want %0d",
						result_ch.type_code, want.type_code));
				if (result_ch.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d",
						result_ch.status, want.status));
			end
		end
	end

	function automatic logic is_size_letter(input logic [7:0] c);
		return c == ilp_pkg::CHAR_L || c == ilp_pkg::CHAR_S || c == ilp_pkg::CHAR_I;
	endfunction

	task automatic append_char(input logic [7:0] c);
		literal_buf.insert(literal_buf.size(), c);
	endtask

	task automatic clear_parse_state();
		lit_index = '0;
		lit_negative = 1'b0;
		lit_radix = ilp_pkg::RADIX_DEC;
		acc_now = '0;
		acc_before_last = '0;
		acc_before_second = '0;
		lit_prev_char = '0;
		lit_status = ilp_pkg::STATUS_OK;
	endtask

	task automatic track_literal_char(input logic [7:0] c, input logic is_final);
		logic               had_prev;
		logic               bad;
		logic               consumed;
		logic [7:0]         old_prev;
		logic [1:0]         dpos;
		int                 base;
		int                 d;
		int                 drop;
		ilp_pkg::lit_type_t ty;
		logic [63:0]        word;
		logic [63:0]        mask;
		literal_result_t    res;
		had_prev = lit_index != 0;
		old_prev = lit_prev_char;
		dpos = lit_index - 2'(lit_negative);
		bad = 1'b0;
		consumed = 1'b0;
		acc_before_second = acc_before_last;
		acc_before_last = acc_now;
		if (had_prev && is_size_letter(old_prev) && (!is_final || c != ilp_pkg::CHAR_U))
			bad = 1'b1;
		if (c == ilp_pkg::CHAR_DOT) begin
			lit_status = ilp_pkg::STATUS_FLOAT;
		end else if (lit_index == 0 && c == ilp_pkg::CHAR_MINUS) begin
			lit_negative = 1'b1;
		end else begin
			if (dpos == 2'd1 && old_prev == ilp_pkg::CHAR_ZERO) begin
				if (c == ilp_pkg::CHAR_X && !is_final) begin
					lit_radix = ilp_pkg::RADIX_HEX;
					consumed = 1'b1;
				end else begin
					lit_radix = ilp_pkg::RADIX_OCT;
				end
			end
			if (!consumed) begin
				base = lit_radix == ilp_pkg::RADIX_HEX ? 16 :
					(lit_radix == ilp_pkg::RADIX_OCT ? 8 : 10);
				d = 16;
				if (c >= ilp_pkg::CHAR_ZERO && c <= ilp_pkg::CHAR_NINE)
					d = int'(c) - int'(ilp_pkg::CHAR_ZERO);
				else if (c >= ilp_pkg::CHAR_LA && c <= ilp_pkg::CHAR_LF)
					d = int'(c) - int'(ilp_pkg::CHAR_LA) + 10;
				else if (c >= ilp_pkg::CHAR_UA && c <= ilp_pkg::CHAR_UF)
					d = int'(c) - int'(ilp_pkg::CHAR_UA) + 10;
				if (d < base) acc_now = acc_now * 64'(base) + 64'(d);
				else if (!is_size_letter(c) && !(is_final && c == ilp_pkg::CHAR_U)) bad = 1'b1;
			end
		end
		if (bad && lit_status == ilp_pkg::STATUS_OK) lit_status = ilp_pkg::STATUS_INVALID;
		lit_prev_char = c;
		if (lit_index != 2'd3) lit_index++;
		if (is_final) begin
			drop = 1;
			if (c == ilp_pkg::CHAR_U) begin
				ty = ilp_pkg::TYPE_U32;
				if (had_prev && is_size_letter(old_prev)) begin
					drop = 2;
					if (old_prev == ilp_pkg::CHAR_L) ty = ilp_pkg::TYPE_U64;
					else if (old_prev == ilp_pkg::CHAR_S) ty = ilp_pkg::TYPE_U16;
					else ty = ilp_pkg::TYPE_U32;
				end
			end else if (c == ilp_pkg::CHAR_L) begin
				ty = ilp_pkg::TYPE_I64;
			end else if (c == ilp_pkg::CHAR_S) begin
				ty = ilp_pkg::TYPE_I16;
			end else if (c == ilp_pkg::CHAR_I) begin
				ty = ilp_pkg::TYPE_I32;
			end else begin
				ty = ilp_pkg::TYPE_I32;
				drop = 0;
			end
			word = drop == 2 ? acc_before_second : (drop == 1 ? acc_before_last : acc_now);
			if (lit_negative && ty != ilp_pkg::TYPE_U64) begin
				if (ty == ilp_pkg::TYPE_I64) mask = '1;
				else if (ty == ilp_pkg::TYPE_I16 || ty == ilp_pkg::TYPE_U16) mask = 64'hFFFF;
				else mask = 64'hFFFF_FFFF;
				word = (word & ~mask) | ((64'd0 - word) & mask);
			end
			if (lit_status != ilp_pkg::STATUS_OK) begin
				word = '0;
				ty = ilp_pkg::TYPE_I32;
			end
			res.value_word = word;
			res.type_code = ty;
			res.status = lit_status;
			expected_literals.insert(expected_literals.size(), res);
			clear_parse_state();
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic is_final);
		while ($urandom_range(99) < send_idle_pct) begin
			char_ch.valid = 1'b0;
			@(negedge clk);
		end
		char_ch.valid = 1'b1;
		char_ch.char_in = c;
		char_ch.is_last = is_final;
		@(posedge clk);
		while (!char_ch.ready) @(posedge clk);
		track_literal_char(c, is_final);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_buffer();
		foreach (literal_buf[i]) send_char(literal_buf[i], i == literal_buf.size() - 1);
	endtask

	task automatic build_wellformed();
		int ndig;
		int h;
		literal_buf.delete();
		if ($urandom_range(2) == 0) append_char(ilp_pkg::CHAR_MINUS);
		ndig = $urandom_range(9) == 0 ? $urandom_range(24, 17) : $urandom_range(6, 1);
		case ($urandom_range(3))
			0: begin
				append_char(8'(ilp_pkg::CHAR_ZERO + $urandom_range(9, 1)));
				repeat (ndig - 1) append_char(8'(ilp_pkg::CHAR_ZERO + $urandom_range(9)));
			end
			1: begin
				append_char(ilp_pkg::CHAR_ZERO);
				repeat (ndig) append_char(8'(ilp_pkg::CHAR_ZERO + $urandom_range(7)));
			end
			2: begin
				append_char(ilp_pkg::CHAR_ZERO);
				append_char(ilp_pkg::CHAR_X);
				repeat (ndig) begin
					h = $urandom_range(15);
					if (h < 10) append_char(8'(ilp_pkg::CHAR_ZERO + h));
					else if ($urandom_range(1)) append_char(8'(ilp_pkg::CHAR_LA + h - 10));
					else append_char(8'(ilp_pkg::CHAR_UA + h - 10));
				end
			end
			default: append_char(ilp_pkg::CHAR_ZERO);
		endcase
		case ($urandom_range(7))
			1: append_char(ilp_pkg::CHAR_U);
			2: append_char(ilp_pkg::CHAR_L);
			3: append_char(ilp_pkg::CHAR_S);
			4: append_char(ilp_pkg::CHAR_I);
			5: begin append_char(ilp_pkg::CHAR_L); append_char(ilp_pkg::CHAR_U); end
			6: begin append_char(ilp_pkg::CHAR_S); append_char(ilp_pkg::CHAR_U); end
			7: begin append_char(ilp_pkg::CHAR_I); append_char(ilp_pkg::CHAR_U); end
			default: ;
		endcase
	endtask

	task automatic test_directed_literals();
		string texts[] = '{"0", "-7", "0x", "0x1Fa", "017", "08", "5u", "-5lu", "-5su",
			"-5iu", "-5l", "-5s", "-5i", "-5u", "1.2", "9z", "u5", "l", "-", "1x.",
			"-0xfE", "7ls", "--1"};
		foreach (texts[i]) send_text(texts[i]);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
	endtask

	task automatic test_random_literals(input int char_budget);
		int sent;
		int pos;
		logic [7:0] odd_chars[] = '{ilp_pkg::CHAR_U, ilp_pkg::CHAR_L, ilp_pkg::CHAR_S,
			ilp_pkg::CHAR_I, ilp_pkg::CHAR_X, ilp_pkg::CHAR_MINUS, ilp_pkg::CHAR_DOT,
			ilp_pkg::CHAR_ZERO};
		sent = 0;
		while (sent < char_budget) begin
			build_wellformed();
			if ($urandom_range(99) < 20) begin
				pos = $urandom_range(literal_buf.size() - 1);
				case ($urandom_range(3))
					0: literal_buf[pos] = 8'($urandom_range(255));
					1: literal_buf.insert(pos, ilp_pkg::CHAR_DOT);
					2: literal_buf.insert(pos, odd_chars[$urandom_range(odd_chars.size() - 1)]);
					default: begin
						literal_buf.delete();
						repeat ($urandom_range(5, 1)) append_char(8'($urandom_range(255)));
					end
				endcase
			end
			send_buffer();
			sent += literal_buf.size();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.char_in = '0;
		char_ch.is_last = 1'b0;
		result_ch.ready = 1'b0;
		clear_parse_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_literals();
		test_random_literals(270);
		send_idle_pct = 72;
		test_random_literals(270);
		send_idle_pct = 0;
		recv_stall_pct = 72;
		test_random_literals(270);
		send_idle_pct = 21;
		recv_stall_pct = 21;
		test_random_literals(270);
		char_ch.valid = 1'b0;

		// drain, then keep clocking to catch stray results
		while (expected_literals.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/ilp_pkg.sv
rtl/core/ilp_char_if.sv
rtl/core/ilp_result_if.sv
rtl/core/integer_literal_parser.sv
rtl/core/ilp_checker.sv
tb/testbench.sv
